// File: src/point_segment_clearance_check_macros.svh
// ----------------------------------------------------------------------------
// point_segment_clearance_check_macros
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_CLEARANCE_CHECK_MACROS_SVH
`define POINT_SEGMENT_CLEARANCE_CHECK_MACROS_SVH

// same-cycle implication
`ifndef SYNTH
`define PSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
`else
`define PSC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`endif

// next-cycle implication
`ifndef SYNTH
`define PSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define PSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// shared constants, command codes and pipeline tag type
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

  // default sizes
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int COORD_WIDTH_DEF  = 32;

  // digit width of one multiplier cell
  localparam int DIGIT_W = 12;

  // clearance threshold register
  localparam int          THR_W     = 31;
  localparam int          THR2_W    = 2 * THR_W;
  localparam logic [30:0] THR_RESET = 31'd32768;

  // command codes
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } psc_cmd_t;

  // tag that travels with each segment through the distance pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } psc_tag_t;

endpackage

`default_nettype wire

// File: src/psc_in_if.sv
// ----------------------------------------------------------------------------
// psc_in_if
// command channel: clear, append segment or query point
// ----------------------------------------------------------------------------
`default_nettype none

interface psc_in_if #(
  parameter int COORD_WIDTH = psc_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] first_z;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;
  logic signed [COORD_WIDTH-1:0] second_z;

  modport source (
    output valid, cmd, first_x, first_y, first_z, second_x, second_y, second_z,
    input  ready
  );
  modport sink (
    input  valid, cmd, first_x, first_y, first_z, second_x, second_y, second_z,
    output ready
  );
endinterface

`default_nettype wire

// File: src/psc_out_if.sv
// ----------------------------------------------------------------------------
// psc_out_if
// query result channel
// ----------------------------------------------------------------------------
`default_nettype none

interface psc_out_if #(
  parameter int MAX_SEGMENTS = psc_pkg::MAX_SEGMENTS_DEF
);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  logic             valid;
  logic             ready;
  logic             obstacle_free;
  logic             table_overflow;
  logic [CNT_W-1:0] segment_count;

  modport source (
    output valid, obstacle_free, table_overflow, segment_count,
    input  ready
  );
  modport sink (
    input  valid, obstacle_free, table_overflow, segment_count,
    output ready
  );
endinterface

`default_nettype wire

// File: src/psc_ram.sv
// ----------------------------------------------------------------------------
// psc_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module psc_ram #(
  parameter int WIDTH  = 6 * psc_pkg::COORD_WIDTH_DEF,
  parameter int DEPTH  = psc_pkg::MAX_SEGMENTS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/psc_mul_cell.sv
// ----------------------------------------------------------------------------
// psc_mul_cell
// one multiplier cell: adds a times one digit of b into the running sum
// ----------------------------------------------------------------------------
`default_nettype none

module psc_mul_cell #(
  parameter int AW  = psc_pkg::COORD_WIDTH_DEF + 1,
  parameter int BP  = 3 * psc_pkg::DIGIT_W,
  parameter int PW  = 2 * (psc_pkg::COORD_WIDTH_DEF + 1),
  parameter int IDX = 0,
  parameter bit TOP = 1'b0
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a_i,
  input  logic [BP-1:0]        b_i,
  input  logic signed [PW-1:0] acc_i,
  output logic signed [AW-1:0] a_o,
  output logic [BP-1:0]        b_o,
  output logic signed [PW-1:0] acc_o
);

  import psc_pkg::*;

  localparam int SH = IDX * DIGIT_W;

  logic [DIGIT_W-1:0]          digit;
  logic signed [DIGIT_W:0]     dext;
  logic signed [AW+DIGIT_W:0]  prod;

  // top digit carries the sign of b
  assign digit = b_i[SH +: DIGIT_W];
  assign dext  = TOP ? $signed({digit[DIGIT_W-1], digit}) : $signed({1'b0, digit});
  assign prod  = a_i * dext;

  // hand operands and partial sum to the next cell
  always_ff @(posedge clk) begin
    a_o   <= a_i;
    b_o   <= b_i;
    acc_o <= acc_i + (PW'(prod) <<< SH);
  end

endmodule

`default_nettype wire

// File: src/psc_mul_chain.sv
// ----------------------------------------------------------------------------
// psc_mul_chain
// signed multiplier built as a row of digit cells, one digit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module psc_mul_chain #(
  parameter int AW = psc_pkg::COORD_WIDTH_DEF + 1,
  parameter int BW = psc_pkg::COORD_WIDTH_DEF + 1,
  parameter int PW = AW + BW
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [PW-1:0] p
);

  import psc_pkg::*;

  localparam int NDIG = (BW + DIGIT_W - 1) / DIGIT_W;
  localparam int BP   = NDIG * DIGIT_W;

  logic signed [AW-1:0] a_s   [0:NDIG];
  logic [BP-1:0]        b_s   [0:NDIG];
  logic signed [PW-1:0] acc_s [0:NDIG];

  // chain entry
  assign a_s[0]   = a;
  assign b_s[0]   = BP'(b);
  assign acc_s[0] = '0;

  // row of cells, least significant digit first
  for (genvar k = 0; k < NDIG; k++) begin : g_cell
    psc_mul_cell #(
      .AW  (AW),
      .BP  (BP),
      .PW  (PW),
      .IDX (k),
      .TOP (k == NDIG - 1)
    ) u_cell (
      .clk   (clk),
      .a_i   (a_s[k]),
      .b_i   (b_s[k]),
      .acc_i (acc_s[k]),
      .a_o   (a_s[k+1]),
      .b_o   (b_s[k+1]),
      .acc_o (acc_s[k+1])
    );
  end

  assign p = (a_s[NDIG] == a_s[NDIG] && b_s[NDIG] == b_s[NDIG]) ? acc_s[NDIG] : acc_s[NDIG];

endmodule

`default_nettype wire

// File: src/psc_dist_unit.sv
// ----------------------------------------------------------------------------
// psc_dist_unit
// pipelined point to segment test, one segment per cycle, exact integer math
// ----------------------------------------------------------------------------
`default_nettype none

module psc_dist_unit #(
  parameter int COORD_WIDTH = psc_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic signed [COORD_WIDTH-1:0]   sx,
  input  logic signed [COORD_WIDTH-1:0]   sy,
  input  logic signed [COORD_WIDTH-1:0]   sz,
  input  logic signed [COORD_WIDTH-1:0]   ex,
  input  logic signed [COORD_WIDTH-1:0]   ey,
  input  logic signed [COORD_WIDTH-1:0]   ez,
  input  logic signed [COORD_WIDTH-1:0]   px,
  input  logic signed [COORD_WIDTH-1:0]   py,
  input  logic signed [COORD_WIDTH-1:0]   pz,
  input  logic [psc_pkg::THR2_W-1:0]      thr2,
  input  psc_pkg::psc_tag_t               tag_i,
  output logic                            close_o,
  output psc_pkg::psc_tag_t               tag_o
);

  import psc_pkg::*;

  localparam int D   = COORD_WIDTH + 1;
  localparam int P1  = 2 * D;
  localparam int SD  = 2 * D + 2;
  localparam int SC  = 2 * D + 1;
  localparam int AW2 = SD;
  localparam int BW2 = (SD > THR2_W + 1) ? SD : THR2_W + 1;
  localparam int PW2 = AW2 + BW2;
  localparam int SC2 = PW2 + 2;
  localparam int L1  = (D + DIGIT_W - 1) / DIGIT_W;
  localparam int L2  = (BW2 + DIGIT_W - 1) / DIGIT_W;

  // stage 1: edge vectors
  logic signed [D-1:0] vx_r, vy_r, vz_r, wx_r, wy_r, wz_r, ux_r, uy_r, uz_r;
  psc_tag_t            tag1_r;

  always_ff @(posedge clk) begin
    vx_r <= D'(ex) - D'(sx);
    vy_r <= D'(ey) - D'(sy);
    vz_r <= D'(ez) - D'(sz);
    wx_r <= D'(px) - D'(sx);
    wy_r <= D'(py) - D'(sy);
    wz_r <= D'(pz) - D'(sz);
    ux_r <= D'(px) - D'(ex);
    uy_r <= D'(py) - D'(ey);
    uz_r <= D'(pz) - D'(ez);
  end

  // first product level: dots and cross terms
  logic signed [D-1:0]  ma [0:17];
  logic signed [D-1:0]  mb [0:17];
  logic signed [P1-1:0] mp [0:17];

  assign ma[0]  = vx_r; assign mb[0]  = vx_r;
  assign ma[1]  = vy_r; assign mb[1]  = vy_r;
  assign ma[2]  = vz_r; assign mb[2]  = vz_r;
  assign ma[3]  = wx_r; assign mb[3]  = vx_r;
  assign ma[4]  = wy_r; assign mb[4]  = vy_r;
  assign ma[5]  = wz_r; assign mb[5]  = vz_r;
  assign ma[6]  = wx_r; assign mb[6]  = wx_r;
  assign ma[7]  = wy_r; assign mb[7]  = wy_r;
  assign ma[8]  = wz_r; assign mb[8]  = wz_r;
  assign ma[9]  = ux_r; assign mb[9]  = ux_r;
  assign ma[10] = uy_r; assign mb[10] = uy_r;
  assign ma[11] = uz_r; assign mb[11] = uz_r;
  assign ma[12] = wy_r; assign mb[12] = vz_r;
  assign ma[13] = wz_r; assign mb[13] = vy_r;
  assign ma[14] = wz_r; assign mb[14] = vx_r;
  assign ma[15] = wx_r; assign mb[15] = vz_r;
  assign ma[16] = wx_r; assign mb[16] = vy_r;
  assign ma[17] = wy_r; assign mb[17] = vx_r;

  for (genvar i = 0; i < 18; i++) begin : g_mul1
    psc_mul_chain #(.AW(D), .BW(D), .PW(P1)) u_mul (
      .clk (clk),
      .a   (ma[i]),
      .b   (mb[i]),
      .p   (mp[i])
    );
  end

  // tag line across the first product level
  psc_tag_t tag_l1 [0:L1-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      for (int i = 0; i < L1; i++) begin
        tag_l1[i] <= '0;
      end
    end else begin
      tag1_r    <= tag_i;
      tag_l1[0] <= tag1_r;
      for (int i = 1; i < L1; i++) begin
        tag_l1[i] <= tag_l1[i-1];
      end
    end
  end

  // stage 2: dot products and cross vector
  logic signed [SD-1:0] vv_r, wv_r, ww_r, uu_r;
  logic signed [SC-1:0] cx_r, cy_r, cz_r;
  psc_tag_t             tag2_r;

  always_ff @(posedge clk) begin
    vv_r <= SD'(mp[0]) + SD'(mp[1]) + SD'(mp[2]);
    wv_r <= SD'(mp[3]) + SD'(mp[4]) + SD'(mp[5]);
    ww_r <= SD'(mp[6]) + SD'(mp[7]) + SD'(mp[8]);
    uu_r <= SD'(mp[9]) + SD'(mp[10]) + SD'(mp[11]);
    cx_r <= SC'(mp[12]) - SC'(mp[13]);
    cy_r <= SC'(mp[14]) - SC'(mp[15]);
    cz_r <= SC'(mp[16]) - SC'(mp[17]);
  end

  // stage 3: pick the closest feature, endpoint test
  logic signed [BW2-1:0] thr2_s;
  logic                  start_case, end_case;
  logic signed [SD-1:0]  vv3_r;
  logic signed [SC-1:0]  cx3_r, cy3_r, cz3_r;
  logic                  ep3_r, cross3_r;
  psc_tag_t              tag3_r;

  assign thr2_s     = $signed(BW2'(thr2));
  assign start_case = wv_r[SD-1] || (wv_r == '0);
  assign end_case   = (wv_r >= vv_r);

  always_ff @(posedge clk) begin
    vv3_r    <= vv_r;
    cx3_r    <= cx_r;
    cy3_r    <= cy_r;
    cz3_r    <= cz_r;
    ep3_r    <= start_case ? (BW2'(ww_r) < thr2_s) : (BW2'(uu_r) < thr2_s);
    cross3_r <= !start_case && !end_case;
  end

  // second product level: squared cross and scaled threshold
  logic signed [AW2-1:0] qa [0:3];
  logic signed [BW2-1:0] qb [0:3];
  logic signed [PW2-1:0] qp [0:3];

  assign qa[0] = AW2'(cx3_r);  assign qb[0] = BW2'(cx3_r);
  assign qa[1] = AW2'(cy3_r);  assign qb[1] = BW2'(cy3_r);
  assign qa[2] = AW2'(cz3_r);  assign qb[2] = BW2'(cz3_r);
  assign qa[3] = AW2'(vv3_r);  assign qb[3] = thr2_s;

  for (genvar i = 0; i < 4; i++) begin : g_mul2
    psc_mul_chain #(.AW(AW2), .BW(BW2), .PW(PW2)) u_mul (
      .clk (clk),
      .a   (qa[i]),
      .b   (qb[i]),
      .p   (qp[i])
    );
  end

  // side lines across the second product level
  psc_tag_t tag_l2   [0:L2-1];
  logic     ep_l2    [0:L2-1];
  logic     cross_l2 [0:L2-1];

  always_ff @(posedge clk) begin
    ep_l2[0]    <= ep3_r;
    cross_l2[0] <= cross3_r;
    for (int i = 1; i < L2; i++) begin
      ep_l2[i]    <= ep_l2[i-1];
      cross_l2[i] <= cross_l2[i-1];
    end
  end

  // stage 2 to 5 tags and the second-level tag line share one reset block
  logic signed [SC2-1:0] c2_r;
  logic signed [PW2-1:0] rhs_r;
  logic                  ep4_r, cross4_r;
  psc_tag_t              tag4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
      tag_o  <= '0;
      for (int i = 0; i < L2; i++) begin
        tag_l2[i] <= '0;
      end
    end else begin
      tag2_r    <= tag_l1[L1-1];
      tag3_r    <= tag2_r;
      tag_l2[0] <= tag3_r;
      for (int i = 1; i < L2; i++) begin
        tag_l2[i] <= tag_l2[i-1];
      end
      tag4_r <= tag_l2[L2-1];
      tag_o  <= tag4_r;
    end
  end

  // stage 4: squared cross length against threshold times length
  always_ff @(posedge clk) begin
    c2_r     <= SC2'(qp[0]) + SC2'(qp[1]) + SC2'(qp[2]);
    rhs_r    <= qp[3];
    ep4_r    <= ep_l2[L2-1];
    cross4_r <= cross_l2[L2-1];
  end

  // stage 5: verdict
  always_ff @(posedge clk) begin
    close_o <= cross4_r ? (c2_r < SC2'(rhs_r)) : ep4_r;
  end

endmodule

`default_nettype wire

// File: src/point_segment_clearance_check.sv
// ----------------------------------------------------------------------------
// point_segment_clearance_check
// segment table with point clearance queries
// ----------------------------------------------------------------------------
// Clear and append transactions complete without leaving the idle state. A
// query reads the segment table RAM at one segment per cycle into the
// distance pipeline and answers once the verdict of the last segment is back;
// L1 = ceil((COORD_WIDTH+1)/12) and L2 = ceil(max(2*COORD_WIDTH+4, 63)/12) are
// the depths of the two multiplier cell rows. An empty table answers without
// entering the pipeline. No new transaction is taken while a query is in
// flight; clears and appends are taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_segment_clearance_check_macros.svh"

module point_segment_clearance_check #(
  parameter int MAX_SEGMENTS = psc_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_WIDTH  = psc_pkg::COORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  psc_in_if.sink                     in_ch,
  psc_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [psc_pkg::THR_W-1:0]  cfg_wdata
);

  import psc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int ADDR_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int WORD_W = 6 * COORD_WIDTH;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                        state_r;
  logic [THR_W-1:0]              thr_r;
  logic [THR2_W-1:0]             thr2_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          ovf_r;
  logic [ADDR_W-1:0]             rd_addr_r;
  psc_tag_t                      rd_tag_r;
  logic                          free_r;
  logic signed [COORD_WIDTH-1:0] px_r, py_r, pz_r;
  logic                          out_valid_r, out_free_r, out_ovf_r;
  logic [CNT_W-1:0]              out_cnt_r;

  logic                          accept, full, last_issue, out_slot;
  logic                          ram_we;
  logic [WORD_W-1:0]             ram_wdata, ram_rdata;
  psc_tag_t                      res_tag;
  logic                          res_close;

  // handshake
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (cnt_r == CNT_W'(MAX_SEGMENTS));
  assign last_issue  = (CNT_W'(rd_addr_r) + CNT_W'(1) == cnt_r);
  assign out_slot    = !out_valid_r || out_ch.ready;

  // segment table
  assign ram_we    = accept && (in_ch.cmd == CMD_APPEND) && !full;
  assign ram_wdata = {in_ch.second_x, in_ch.second_y, in_ch.second_z,
                      in_ch.first_x, in_ch.first_y, in_ch.first_z};

  psc_ram #(.WIDTH(WORD_W), .DEPTH(MAX_SEGMENTS), .ADDR_W(ADDR_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(cnt_r)),
    .wdata (ram_wdata),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // distance pipeline
  psc_dist_unit #(.COORD_WIDTH(COORD_WIDTH)) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .sx      (ram_rdata[2*COORD_WIDTH +: COORD_WIDTH]),
    .sy      (ram_rdata[COORD_WIDTH +: COORD_WIDTH]),
    .sz      (ram_rdata[0 +: COORD_WIDTH]),
    .ex      (ram_rdata[5*COORD_WIDTH +: COORD_WIDTH]),
    .ey      (ram_rdata[4*COORD_WIDTH +: COORD_WIDTH]),
    .ez      (ram_rdata[3*COORD_WIDTH +: COORD_WIDTH]),
    .px      (px_r),
    .py      (py_r),
    .pz      (pz_r),
    .thr2    (thr2_r),
    .tag_i   (rd_tag_r),
    .close_o (res_close),
    .tag_o   (res_tag)
  );

  // squared threshold
  always_ff @(posedge clk) begin
    thr2_r <= THR2_W'(thr_r) * THR2_W'(thr_r);
  end

  // query point and read address
  always_ff @(posedge clk) begin
    if (accept && (in_ch.cmd == CMD_QUERY)) begin
      px_r <= in_ch.first_x;
      py_r <= in_ch.first_y;
      pz_r <= in_ch.first_z;
    end
    if (state_r == ST_ISSUE) begin
      rd_addr_r <= rd_addr_r + ADDR_W'(1);
    end else begin
      rd_addr_r <= '0;
    end
  end

  // control: table bookkeeping, sequencing and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= THR_RESET;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      rd_tag_r    <= '0;
      free_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end

      rd_tag_r.valid <= (state_r == ST_ISSUE);
      rd_tag_r.last  <= (state_r == ST_ISSUE) && last_issue;

      // result valid: set when the verdict is loaded, cleared when taken
      if (state_r == ST_DONE && out_slot) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_ch.cmd)
              CMD_CLEAR: begin
                cnt_r <= '0;
                ovf_r <= 1'b0;
              end
              CMD_APPEND: begin
                if (full) begin
                  ovf_r <= 1'b1;
                end else begin
                  cnt_r <= cnt_r + CNT_W'(1);
                end
              end
              CMD_QUERY: begin
                free_r  <= 1'b1;
                state_r <= (cnt_r == '0) ? ST_DONE : ST_ISSUE;
              end
              default: ;
            endcase
          end
        end
        ST_ISSUE: begin
          // early segments come back while later ones are still issued
          if (res_tag.valid && res_close) begin
            free_r <= 1'b0;
          end
          if (last_issue) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (res_tag.valid && res_close) begin
            free_r <= 1'b0;
          end
          if (res_tag.valid && res_tag.last) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_slot) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_slot) begin
      out_free_r <= free_r;
      out_ovf_r  <= ovf_r;
      out_cnt_r  <= cnt_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.obstacle_free  = out_free_r;
  assign out_ch.table_overflow = out_ovf_r;
  assign out_ch.segment_count  = out_cnt_r;

  // checks
  `PSC_ASSERT_NOW(a_issue_in_range, clk, rst_n, state_r == ST_ISSUE, CNT_W'(rd_addr_r) < cnt_r)
  `PSC_ASSERT_NOW(a_result_in_query, clk, rst_n, res_tag.valid, state_r == ST_ISSUE || state_r == ST_DRAIN)
  `PSC_ASSERT_NEXT(a_full_sets_ovf, clk, rst_n, accept && in_ch.cmd == CMD_APPEND && full, ovf_r)

endmodule

`default_nettype wire

// File: dv/tb_psc_if_note.sv
// ----------------------------------------------------------------------------
// tb_psc_if_note
// testbench-side helpers: transaction and outcome types for the clearance check
// ----------------------------------------------------------------------------
package tb_psc_types_pkg;
  import psc_pkg::*;

  // one command transaction
  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] fx, fy, fz, sx, sy, sz;
  } psc_txn_t;

  // one query outcome
  typedef struct {
    logic       free;
    logic       ovf;
    logic [6:0] cnt;
  } psc_outcome_t;
endpackage

// File: dv/tb_point_segment_clearance_check.sv
// ----------------------------------------------------------------------------
// tb_point_segment_clearance_check
// self-checking bench for the point to segment clearance checker
// ----------------------------------------------------------------------------
// A directed stimulus table walks empty-table, extreme, zero-length and
// unused-code cases, a fill past capacity covers overflow, then random
// segment tables and queries run through four idling phases. A behavioral
// geometry predictor gives each outcome, compared field by field with out_ch.
// ----------------------------------------------------------------------------
module tb_point_segment_clearance_check;
  timeunit 1ns;
  timeprecision 1ps;
  import psc_pkg::*;
  import tb_psc_types_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int RANDOM_ITEMS   = 1360;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [THR_W-1:0] cfg_wdata;

  psc_in_if  #(.COORD_WIDTH(32))  in_ch ();
  psc_out_if #(.MAX_SEGMENTS(64)) out_ch ();

  point_segment_clearance_check dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // one directed row, with a typed outcome where it is obvious
  typedef struct {
    psc_txn_t     txn;
    bit           has_exp;
    psc_outcome_t exp_o;
  } dir_row_t;

  // predictor state
  logic signed [31:0] tbl_ax [64], tbl_ay [64], tbl_az [64];
  logic signed [31:0] tbl_bx [64], tbl_by [64], tbl_bz [64];
  int unsigned        tbl_count;
  logic               tbl_ovf;
  logic [30:0]        clr_thr;

  psc_outcome_t pending_outcomes [$];
  int  mismatch_count;
  int  send_idle_pct, recv_stall_pct;
  int  idle_cycles;

  // point against one stored segment, exact integer geometry
  function automatic bit seg_too_close(int k, logic signed [31:0] px,
                                       logic signed [31:0] py, logic signed [31:0] pz);
    logic signed [255:0] vx, vy, vz, wx, wy, wz, ux, uy, uz, wv, vv, d2, thr2;
    logic signed [255:0] cx, cy, cz, c2;
    vx = 256'(signed'(33'(tbl_bx[k]) - 33'(tbl_ax[k])));
    vy = 256'(signed'(33'(tbl_by[k]) - 33'(tbl_ay[k])));
    vz = 256'(signed'(33'(tbl_bz[k]) - 33'(tbl_az[k])));
    wx = 256'(signed'(33'(px) - 33'(tbl_ax[k])));
    wy = 256'(signed'(33'(py) - 33'(tbl_ay[k])));
    wz = 256'(signed'(33'(pz) - 33'(tbl_az[k])));
    thr2 = $signed({193'd0, 63'({32'd0, clr_thr} * {32'd0, clr_thr})});
    wv = wx*vx + wy*vy + wz*vz;
    vv = vx*vx + vy*vy + vz*vz;
    if (wv <= 0) begin
      d2 = wx*wx + wy*wy + wz*wz;
      return d2 < thr2;
    end
    if (wv >= vv) begin
      ux = 256'(signed'(33'(px) - 33'(tbl_bx[k])));
      uy = 256'(signed'(33'(py) - 33'(tbl_by[k])));
      uz = 256'(signed'(33'(pz) - 33'(tbl_bz[k])));
      d2 = ux*ux + uy*uy + uz*uz;
      return d2 < thr2;
    end
    cx = wy*vz - wz*vy;
    cy = wz*vx - wx*vz;
    cz = wx*vy - wy*vx;
    c2 = cx*cx + cy*cy + cz*cz;
    return c2 < thr2 * vv;
  endfunction

  // apply one accepted transaction to the table model
  function automatic void predict_clearance(psc_txn_t t);
    psc_outcome_t o;
    case (t.cmd)
      CMD_CLEAR: begin
        tbl_count = 0;
        tbl_ovf   = 1'b0;
      end
      CMD_APPEND: begin
        if (tbl_count < 64) begin
          tbl_ax[tbl_count] = t.fx; tbl_ay[tbl_count] = t.fy; tbl_az[tbl_count] = t.fz;
          tbl_bx[tbl_count] = t.sx; tbl_by[tbl_count] = t.sy; tbl_bz[tbl_count] = t.sz;
          tbl_count++;
        end else begin
          tbl_ovf = 1'b1;
        end
      end
      CMD_QUERY: begin
        o.free = 1'b1;
        for (int k = 0; k < tbl_count; k++)
          if (seg_too_close(k, t.fx, t.fy, t.fz)) begin
            o.free = 1'b0;
            break;
          end
        o.ovf = tbl_ovf;
        o.cnt = 7'(tbl_count);
        pending_outcomes = {pending_outcomes, o};
      end
      default: ;
    endcase
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: stalls and result checking
  initial begin
    psc_outcome_t e;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_outcomes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result transaction");
        end else begin
          e = pending_outcomes.pop_front();
          if (out_ch.obstacle_free !== e.free || out_ch.table_overflow !== e.ovf ||
              out_ch.segment_count !== e.cnt) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp free=%0b ovf=%0b cnt=%0d got free=%0b ovf=%0b cnt=%0d",
                       e.free, e.ovf, e.cnt, out_ch.obstacle_free,
                       out_ch.table_overflow, out_ch.segment_count);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no accepted transaction on either channel
  initial begin
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // hold one transaction until accepted, with random idle before it
  task automatic send_txn(psc_txn_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= t.cmd;
    in_ch.first_x  <= t.fx; in_ch.first_y  <= t.fy; in_ch.first_z  <= t.fz;
    in_ch.second_x <= t.sx; in_ch.second_y <= t.sy; in_ch.second_z <= t.sz;
    do @(posedge clk); while (!in_ch.ready);
    predict_clearance(t);
  endtask

  // wait for all results, then settle before a register write
  task automatic drain_outcomes();
    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [30:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    clr_thr = v;
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return 32'($urandom);
      1: return $signed(32'($urandom_range(0, 1 << 19))) - 32'sd262144;
      default: return $signed(32'($urandom_range(0, 1 << 11))) - 32'sd1024;
    endcase
  endfunction

  function automatic psc_txn_t mk(logic [1:0] c, int fx, int fy, int fz,
                                  int sx, int sy, int sz);
    psc_txn_t t;
    t.cmd = c; t.fx = fx; t.fy = fy; t.fz = fz; t.sx = sx; t.sy = sy; t.sz = sz;
    return t;
  endfunction

  // row checked against the predictor
  function automatic dir_row_t row(psc_txn_t t);
    dir_row_t r;
    r.txn     = t;
    r.has_exp = 1'b0;
    r.exp_o   = '{free: 1'b0, ovf: 1'b0, cnt: 7'd0};
    return r;
  endfunction

  // row with a typed outcome
  function automatic dir_row_t row_exp(psc_txn_t t, logic f, logic v, logic [6:0] c);
    dir_row_t r;
    r.txn     = t;
    r.has_exp = 1'b1;
    r.exp_o   = '{free: f, ovf: v, cnt: c};
    return r;
  endfunction

  // directed stimulus table
  dir_row_t dir_tbl [$];

  initial begin
    psc_txn_t t;
    int mode, n;
    mismatch_count = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    tbl_count      = 0;
    tbl_ovf        = 1'b0;
    clr_thr        = THR_RESET;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_CLEAR;
    in_ch.first_x  = '0; in_ch.first_y  = '0; in_ch.first_z  = '0;
    in_ch.second_x = '0; in_ch.second_y = '0; in_ch.second_z = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, extremes, zero-length segment, unused code, clear
    dir_tbl = {dir_tbl, row_exp(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0), 1'b1, 1'b0, 7'd0)};
    dir_tbl = {dir_tbl, row_exp(mk(CMD_QUERY, 32'h7fffffff, 32'h80000000, -1, 5, 5, 5),
                                1'b1, 1'b0, 7'd0)};
    dir_tbl = {dir_tbl, row(mk(CMD_APPEND, 0, 0, 0, 0, 0, 0))};
    dir_tbl = {dir_tbl, row_exp(mk(CMD_QUERY, 100, 0, 0, 0, 0, 0), 1'b0, 1'b0, 7'd1)};
    dir_tbl = {dir_tbl, row_exp(mk(CMD_QUERY, 40000, 0, 0, 0, 0, 0), 1'b1, 1'b0, 7'd1)};
    dir_tbl = {dir_tbl, row(mk(CMD_APPEND, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h7fffffff, 32'h7fffffff, 32'h7fffffff))};
    dir_tbl = {dir_tbl, row(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0))};
    dir_tbl = {dir_tbl, row(mk(CMD_QUERY, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0))};
    dir_tbl = {dir_tbl, row(mk(CMD_QUERY, 32'h80000000, 32'h80000000, 32'h80000000,
                               0, 0, 0))};
    dir_tbl = {dir_tbl, row(mk(2'd3, 1, 2, 3, 4, 5, 6))};
    dir_tbl = {dir_tbl, row(mk(CMD_APPEND, 0, 0, 0, 65536, 0, 0))};
    dir_tbl = {dir_tbl, row(mk(CMD_QUERY, 32768, 32768, 0, 0, 0, 0))};
    dir_tbl = {dir_tbl, row(mk(CMD_QUERY, 32768, 32767, 0, 0, 0, 0))};
    dir_tbl = {dir_tbl, row(mk(CMD_QUERY, 98304, 0, 0, 0, 0, 0))};
    dir_tbl = {dir_tbl, row(mk(CMD_CLEAR, -1, -1, -1, -1, -1, -1))};
    dir_tbl = {dir_tbl, row_exp(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0), 1'b1, 1'b0, 7'd0)};
    foreach (dir_tbl[i]) begin
      send_txn(dir_tbl[i].txn);
      if (dir_tbl[i].has_exp) pending_outcomes[$] = dir_tbl[i].exp_o;
    end

    // fill past capacity, then query the overflowed table
    for (int i = 0; i < 66; i++)
      send_txn(mk(CMD_APPEND, i * 65536, 0, 0, i * 65536, 65536, 0));
    send_txn(mk(CMD_QUERY, 10 * 65536, 65536, 0, 0, 0, 0));
    send_txn(mk(CMD_QUERY, 10 * 65536, -200000, 0, 0, 0, 0));

    // sender holds off until all results are back
    drain_outcomes();
    write_threshold(31'd0);
    send_txn(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    send_txn(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    drain_outcomes();
    write_threshold(31'h7fffffff);
    send_txn(mk(CMD_APPEND, 0, 0, 0, 1, 1, 1));
    send_txn(mk(CMD_QUERY, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0));

    // random phases with different idling and thresholds
    n = 0;
    for (int ph = 0; ph < 4; ph++) begin
      drain_outcomes();
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      write_threshold(ph == 3 ? 31'($urandom) : 31'($urandom_range(0, 1 << 19)));
      send_txn(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
      while (n < RANDOM_ITEMS * (ph + 1) / 4) begin
        mode = $urandom_range(2);
        case ($urandom_range(99)) inside
          [0:2]:   t = mk(CMD_CLEAR, $urandom, $urandom, $urandom, 0, 0, 0);
          [3:4]:   t = mk(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          [5:40]: begin
            t = mk(CMD_APPEND, rand_coord(mode), rand_coord(mode), rand_coord(mode),
                   rand_coord(mode), rand_coord(mode), rand_coord(mode));
            if ($urandom_range(9) == 0) begin t.sx = t.fx; t.sy = t.fy; t.sz = t.fz; end
          end
          default: t = mk(CMD_QUERY, rand_coord(mode), rand_coord(mode), rand_coord(mode),
                          $urandom, $urandom, $urandom);
        endcase
        send_txn(t);
        n++;
      end
    end

    drain_outcomes();
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+src
src/psc_pkg.sv
src/psc_in_if.sv
src/psc_out_if.sv
src/psc_ram.sv
src/psc_mul_cell.sv
src/psc_mul_chain.sv
src/psc_dist_unit.sv
src/point_segment_clearance_check.sv
dv/tb_psc_if_note.sv
dv/tb_point_segment_clearance_check.sv
